@@ src/qfds_pkg.sv @@
// Shared types and constants for the quick-find disjoint set block.
// No dependencies; the saturating unit, the top level and the testbench import this package.
package qfds_pkg;

  localparam int unsigned IDX_W  = 6;   // element and group index fields
  localparam int unsigned SIZE_W = 7;   // group sizes and group count
  localparam int unsigned CFG_DW = 32;  // configuration data bus
  localparam int unsigned CFG_AW = 3;   // configuration byte address

  localparam logic [SIZE_W-1:0] SIZE_MAX     = 7'd127;
  localparam logic [SIZE_W-1:0] GROUPS_RESET = 7'd64;

  typedef enum logic [1:0] {
    FUNC_ASSIGN = 2'd0,
    FUNC_MERGE  = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_t;

  // Register index as decoded from the word address.
  typedef enum logic {
    REG_INITIAL_GROUPS = 1'b0
  } reg_idx_t;

  typedef enum logic {
    SAT_ADD = 1'b0,
    SAT_SUB = 1'b1
  } sat_op_t;

  typedef enum logic [3:0] {
    S_INIT,
    S_IDLE,
    S_REDUCE,
    S_A_INC,
    S_M_LAB,
    S_M_SX,
    S_M_SY,
    S_SCAN,
    S_M_WX,
    S_M_WY,
    S_RES1,
    S_RES2,
    S_RES3
  } state_t;

endpackage

@@ src/qfds_ram.sv @@
// Single-port-write, single-port-read memory with registered read data.
// Depends on nothing; used for the label and size stores.
module qfds_ram #(
  parameter int unsigned DW    = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/qfds_sat_unit.sv @@
// Shared saturating add/subtract unit for sizes and the group count.
// Depends on qfds_pkg for the size width and the operation type.
module qfds_sat_unit #(
  parameter int unsigned CW = 7
) (
  input  qfds_pkg::sat_op_t               op,
  input  logic [qfds_pkg::SIZE_W-1:0]     a,
  input  logic [CW-1:0]                   b,
  output logic [qfds_pkg::SIZE_W-1:0]     y
);
  import qfds_pkg::*;

  localparam int unsigned SW = CW + SIZE_W + 1;

  logic [SW-1:0] a_ext;
  logic [SW-1:0] b_ext;
  logic [SW-1:0] sum;
  logic [SW-1:0] diff;

  assign a_ext = SW'(a);
  assign b_ext = SW'(b);
  assign sum   = a_ext + b_ext;
  assign diff  = a_ext - b_ext;

  // Additions clamp at the all-ones size, subtractions at zero.
  always_comb begin
    case (op)
      SAT_ADD: y = (sum > SW'(SIZE_MAX)) ? SIZE_MAX : sum[SIZE_W-1:0];
      SAT_SUB: y = (b_ext > a_ext) ? '0 : diff[SIZE_W-1:0];
      default: y = a;
    endcase
  end

endmodule

@@ src/quick_find_disjoint_set.sv @@
// Top level of the quick-find disjoint set: sequencer, registers, APB port.
// Depends on qfds_pkg, qfds_ram and qfds_sat_unit.
//
//   port group   direction  handshake                  payload
//   in_*         input      in_valid / in_stall        func, elem_x, elem_y, group_id
//   out_*        output     out_valid / out_stall      x_group .. group_count
//   APB          input      psel, penable, pwrite      paddr, pwdata, prdata
//
// A query steps through S_REDUCE, S_RES1, S_RES2 and S_RES3; an assign adds S_A_INC, and a
// merge of two separate groups adds S_M_LAB, S_M_SX, S_M_SY, the scan that reads one label
// per cycle from the label memory, then S_M_WX and S_M_WY. With ELEMENTS below 64 each
// index field is first reduced in S_REDUCE by one subtraction per cycle.
// After reset a clearing pass writes every label to its own index and every size to zero;
// no transaction is accepted meanwhile, but register writes are.
// A finished result waits in the output register; the next transaction may be accepted
// while it waits, and the sequencer holds its last step until the output is free.
module quick_find_disjoint_set #(
  parameter int unsigned ELEMENTS = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,

  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [1:0]                     in_func,
  input  logic [qfds_pkg::IDX_W-1:0]     in_elem_x,
  input  logic [qfds_pkg::IDX_W-1:0]     in_elem_y,
  input  logic [qfds_pkg::IDX_W-1:0]     in_group_id,

  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [qfds_pkg::IDX_W-1:0]     out_x_group,
  output logic                           out_same_group,
  output logic [qfds_pkg::SIZE_W-1:0]    out_x_group_size,
  output logic                           out_x_alone,
  output logic [qfds_pkg::SIZE_W-1:0]    out_named_group_size,
  output logic [qfds_pkg::SIZE_W-1:0]    out_group_count,

  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [qfds_pkg::CFG_AW-1:0]    paddr,
  input  logic [qfds_pkg::CFG_DW-1:0]    pwdata,
  output logic [qfds_pkg::CFG_DW-1:0]    prdata,
  output logic                           pready
);
  import qfds_pkg::*;

  // Label width, and the width of counters that must also hold ELEMENTS itself.
  localparam int unsigned LW = $clog2(ELEMENTS);
  localparam int unsigned CW = $clog2(ELEMENTS + 1);

  // Sequencer and item registers.
  state_t              state_r,  state_nxt;
  func_t               func_r,   func_nxt;
  logic [IDX_W-1:0]    x_r,      x_nxt;
  logic [IDX_W-1:0]    y_r,      y_nxt;
  logic [IDX_W-1:0]    gid_r,    gid_nxt;
  logic [CW-1:0]       scan_r,   scan_nxt;
  logic [CW-1:0]       n_r,      n_nxt;
  logic [LW-1:0]       gx_r,     gx_nxt;
  logic [LW-1:0]       gy_r,     gy_nxt;
  logic [SIZE_W-1:0]   sx_r,     sx_nxt;
  logic [SIZE_W-1:0]   sy_r,     sy_nxt;
  logic [SIZE_W-1:0]   szgid_r,  szgid_nxt;
  logic [SIZE_W-1:0]   count_r,  count_nxt;
  logic [SIZE_W-1:0]   igroups_r, igroups_nxt;

  // Output register.
  logic                out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]    ox_group_r,  ox_group_nxt;
  logic                osame_r,     osame_nxt;
  logic [SIZE_W-1:0]   oxsize_r,    oxsize_nxt;
  logic                oalone_r,    oalone_nxt;
  logic [SIZE_W-1:0]   onamed_r,    onamed_nxt;
  logic [SIZE_W-1:0]   ocount_r,    ocount_nxt;

  // Memory and shared unit connections.
  logic                lab_we;
  logic [LW-1:0]       lab_waddr, lab_wdata;
  logic [LW-1:0]       lab_raddr_a, lab_raddr_b;
  logic [LW-1:0]       lab_rdata_a, lab_rdata_b;
  logic                sz_we;
  logic [LW-1:0]       sz_waddr, sz_raddr;
  logic [SIZE_W-1:0]   sz_wdata, sz_rdata;
  sat_op_t             sat_op;
  logic [SIZE_W-1:0]   sat_a, sat_y;
  logic [CW-1:0]       sat_b;

  logic                in_xfer;
  logic                out_xfer;
  logic                cfg_wr;
  logic                x_big, y_big, gid_big;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign cfg_wr   = psel && penable && pwrite && pready &&
                    (reg_idx_t'(paddr[2]) == REG_INITIAL_GROUPS);

  assign in_stall = (state_r != S_IDLE);
  assign pready   = 1'b1;
  assign prdata   = CFG_DW'(igroups_r);

  assign out_valid            = out_valid_r;
  assign out_x_group          = ox_group_r;
  assign out_same_group       = osame_r;
  assign out_x_group_size     = oxsize_r;
  assign out_x_alone          = oalone_r;
  assign out_named_group_size = onamed_r;
  assign out_group_count      = ocount_r;

  // Index fields wrap modulo ELEMENTS; these only fire when ELEMENTS is below 64.
  assign x_big   = (32'(x_r)   >= ELEMENTS);
  assign y_big   = (32'(y_r)   >= ELEMENTS);
  assign gid_big = (32'(gid_r) >= ELEMENTS);

  // Two label memories are written identically so that two labels can be read at once.
  qfds_ram #(.DW(LW), .DEPTH(ELEMENTS), .AW(LW)) u_lab_a (
    .clk   (clk),
    .we    (lab_we),
    .waddr (lab_waddr),
    .wdata (lab_wdata),
    .raddr (lab_raddr_a),
    .rdata (lab_rdata_a)
  );

  qfds_ram #(.DW(LW), .DEPTH(ELEMENTS), .AW(LW)) u_lab_b (
    .clk   (clk),
    .we    (lab_we),
    .waddr (lab_waddr),
    .wdata (lab_wdata),
    .raddr (lab_raddr_b),
    .rdata (lab_rdata_b)
  );

  qfds_ram #(.DW(SIZE_W), .DEPTH(ELEMENTS), .AW(LW)) u_size (
    .clk   (clk),
    .we    (sz_we),
    .waddr (sz_waddr),
    .wdata (sz_wdata),
    .raddr (sz_raddr),
    .rdata (sz_rdata)
  );

  qfds_sat_unit #(.CW(CW)) u_sat (
    .op (sat_op),
    .a  (sat_a),
    .b  (sat_b),
    .y  (sat_y)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      scan_r      <= '0;
      count_r     <= GROUPS_RESET;
      igroups_r   <= GROUPS_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_r      <= scan_nxt;
      count_r     <= count_nxt;
      igroups_r   <= igroups_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    gid_r      <= gid_nxt;
    n_r        <= n_nxt;
    gx_r       <= gx_nxt;
    gy_r       <= gy_nxt;
    sx_r       <= sx_nxt;
    sy_r       <= sy_nxt;
    szgid_r    <= szgid_nxt;
    ox_group_r <= ox_group_nxt;
    osame_r    <= osame_nxt;
    oxsize_r   <= oxsize_nxt;
    oalone_r   <= oalone_nxt;
    onamed_r   <= onamed_nxt;
    ocount_r   <= ocount_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    gid_nxt       = gid_r;
    scan_nxt      = scan_r;
    n_nxt         = n_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    szgid_nxt     = szgid_r;
    count_nxt     = count_r;
    igroups_nxt   = igroups_r;
    out_valid_nxt = out_valid_r && !out_xfer;
    ox_group_nxt  = ox_group_r;
    osame_nxt     = osame_r;
    oxsize_nxt    = oxsize_r;
    oalone_nxt    = oalone_r;
    onamed_nxt    = onamed_r;
    ocount_nxt    = ocount_r;

    lab_we      = 1'b0;
    lab_waddr   = LW'(x_r);
    lab_wdata   = LW'(gid_r);
    lab_raddr_a = LW'(x_r);
    lab_raddr_b = LW'(y_r);
    sz_we       = 1'b0;
    sz_waddr    = LW'(gid_r);
    sz_wdata    = sat_y;
    sz_raddr    = LW'(gid_r);
    sat_op      = SAT_ADD;
    sat_a       = sz_rdata;
    sat_b       = CW'(1);

    case (state_r)
      // Clearing pass: label i takes i, size i takes zero.
      S_INIT: begin
        lab_we    = 1'b1;
        lab_waddr = LW'(scan_r);
        lab_wdata = LW'(scan_r);
        sz_we     = 1'b1;
        sz_waddr  = LW'(scan_r);
        sz_wdata  = '0;
        scan_nxt  = scan_r + CW'(1);
        if (scan_r == CW'(ELEMENTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_xfer) begin
          func_nxt  = func_t'(in_func);
          x_nxt     = in_elem_x;
          y_nxt     = in_elem_y;
          gid_nxt   = in_group_id;
          state_nxt = S_REDUCE;
        end
      end

      S_REDUCE: begin
        if (x_big || y_big || gid_big) begin
          if (x_big) begin
            x_nxt = x_r - IDX_W'(ELEMENTS);
          end
          if (y_big) begin
            y_nxt = y_r - IDX_W'(ELEMENTS);
          end
          if (gid_big) begin
            gid_nxt = gid_r - IDX_W'(ELEMENTS);
          end
        end else begin
          case (func_r)
            FUNC_ASSIGN: begin
              lab_we    = 1'b1;
              state_nxt = S_A_INC;
            end
            FUNC_MERGE: begin
              state_nxt = S_M_LAB;
            end
            default: begin
              state_nxt = S_RES1;
            end
          endcase
        end
      end

      // The size of the named group is on the read port; bump it by one.
      S_A_INC: begin
        sz_we     = 1'b1;
        state_nxt = S_RES1;
      end

      S_M_LAB: begin
        gx_nxt   = lab_rdata_a;
        gy_nxt   = lab_rdata_b;
        sz_raddr = lab_rdata_a;
        if (lab_rdata_a == lab_rdata_b) begin
          state_nxt = S_RES1;
        end else begin
          sat_op    = SAT_SUB;
          sat_a     = count_r;
          count_nxt = sat_y;
          n_nxt     = '0;
          state_nxt = S_M_SX;
        end
      end

      S_M_SX: begin
        sx_nxt    = sz_rdata;
        sz_raddr  = gy_r;
        state_nxt = S_M_SY;
      end

      S_M_SY: begin
        sy_nxt      = sz_rdata;
        lab_raddr_a = '0;
        scan_nxt    = CW'(1);
        state_nxt   = S_SCAN;
      end

      // One label per cycle: the data on the port belongs to index scan_r - 1.
      S_SCAN: begin
        lab_raddr_a = LW'(scan_r);
        lab_waddr   = LW'(scan_r - CW'(1));
        lab_wdata   = gy_r;
        if (lab_rdata_a == gx_r) begin
          lab_we = 1'b1;
          n_nxt  = n_r + CW'(1);
        end
        scan_nxt = scan_r + CW'(1);
        if (scan_r == CW'(ELEMENTS)) begin
          state_nxt = S_M_WX;
        end
      end

      // Moving n members one at a time is a clamped subtract of n and a clamped add of n.
      S_M_WX: begin
        sat_op    = SAT_SUB;
        sat_a     = sx_r;
        sat_b     = n_r;
        sz_we     = 1'b1;
        sz_waddr  = gx_r;
        state_nxt = S_M_WY;
      end

      S_M_WY: begin
        sat_op    = SAT_ADD;
        sat_a     = sy_r;
        sat_b     = n_r;
        sz_we     = 1'b1;
        sz_waddr  = gy_r;
        state_nxt = S_RES1;
      end

      S_RES1: begin
        state_nxt = S_RES2;
      end

      S_RES2: begin
        szgid_nxt = sz_rdata;
        gx_nxt    = lab_rdata_a;
        gy_nxt    = lab_rdata_b;
        sz_raddr  = lab_rdata_a;
        state_nxt = S_RES3;
      end

      // Size of x's group is on the read port; hold it until the output is free.
      S_RES3: begin
        sz_raddr = gx_r;
        if (!out_valid_r || out_xfer) begin
          out_valid_nxt = 1'b1;
          ox_group_nxt  = IDX_W'(gx_r);
          osame_nxt     = (gx_r == gy_r);
          oxsize_nxt    = sz_rdata;
          oalone_nxt    = (sz_rdata == SIZE_W'(1));
          onamed_nxt    = szgid_r;
          ocount_nxt    = count_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A register write reloads the running count as well.
    if (cfg_wr) begin
      igroups_nxt = pwdata[SIZE_W-1:0];
      count_nxt   = pwdata[SIZE_W-1:0];
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted transaction keeps the input side stalled on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> in_stall)
    else $error("input accepted twice in a row");

  // The group count never grows except through a register write.
  a_count_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_wr |=> count_r <= $past(count_r))
    else $error("group count increased without a register write");

  // A new result only comes from the final step of the sequencer.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (!$past(out_valid_r) || $past(out_xfer)) && !$past(in_xfer)
     && $past(rst_n)) |-> ($past(state_r) == S_RES3))
    else $error("result loaded outside the final step");
`endif

endmodule

@@ tb/tb_quick_find_disjoint_set.sv @@
// Self-checking testbench for the quick-find disjoint set block.
// It drives random and directed transactions and checks each result against its union model or a typed row.
// Depends on qfds_pkg and the quick_find_disjoint_set RTL only.
module tb_quick_find_disjoint_set;
  timeunit 1ns;
  timeprecision 1ps;

  import qfds_pkg::*;

  localparam int unsigned NUM_ELEM      = 64;
  // The block treats the fourth operation code as a plain query.
  localparam logic [1:0]  FUNC_SPARE    = 2'd3;
  localparam logic [CFG_AW-1:0] ADDR_INITIAL_GROUPS =
    CFG_AW'(4 * int'(REG_INITIAL_GROUPS));
  localparam int unsigned DIR_ROWS      = 20;
  localparam int unsigned PHASES        = 5;
  localparam int unsigned PHASE_ITEMS   = 220;
  localparam int unsigned HAMMER_ITEMS  = 130;
  localparam int unsigned IDLE_PCT      = 24;
  localparam int unsigned SETTLE_CYCLES = 100;
  localparam int unsigned LIMIT_NS      = 4_000_000;

  typedef struct packed {
    logic [1:0]       func;
    logic [IDX_W-1:0] elem_x;
    logic [IDX_W-1:0] elem_y;
    logic [IDX_W-1:0] group_id;
  } set_op_t;

  typedef struct packed {
    logic [IDX_W-1:0]  x_group;
    logic              same_group;
    logic [SIZE_W-1:0] x_group_size;
    logic              x_alone;
    logic [SIZE_W-1:0] named_group_size;
    logic [SIZE_W-1:0] group_count;
  } set_report_t;

  // One row of the directed table. When fixed_want is set, the row carries the
  // result typed in by hand; otherwise the union model supplies it.
  typedef struct packed {
    set_op_t     op;
    logic        fixed_want;
    set_report_t want;
  } dir_row_t;

  localparam set_report_t NO_REPORT = '0;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_func;
  logic [IDX_W-1:0]  in_elem_x;
  logic [IDX_W-1:0]  in_elem_y;
  logic [IDX_W-1:0]  in_group_id;
  logic              out_valid;
  logic              out_stall;
  logic [IDX_W-1:0]  out_x_group;
  logic              out_same_group;
  logic [SIZE_W-1:0] out_x_group_size;
  logic              out_x_alone;
  logic [SIZE_W-1:0] out_named_group_size;
  logic [SIZE_W-1:0] out_group_count;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  quick_find_disjoint_set #(
    .ELEMENTS(NUM_ELEM)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_func             (in_func),
    .in_elem_x           (in_elem_x),
    .in_elem_y           (in_elem_y),
    .in_group_id         (in_group_id),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_x_group         (out_x_group),
    .out_same_group      (out_same_group),
    .out_x_group_size    (out_x_group_size),
    .out_x_alone         (out_x_alone),
    .out_named_group_size(out_named_group_size),
    .out_group_count     (out_group_count),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Shadow copy of the block's state: one label per element, one size per
  // group label, the running group count and the register that reloads it.
  logic [IDX_W-1:0]  shadow_label [NUM_ELEM];
  logic [SIZE_W-1:0] shadow_size  [NUM_ELEM];
  logic [SIZE_W-1:0] shadow_groups;
  logic [SIZE_W-1:0] initial_groups_reg;

  // Reports owed by the block, oldest first.
  set_report_t pending_reports [$];

  dir_row_t    dir_table [DIR_ROWS];
  bit          gaps_on = 1'b1;
  int unsigned failures;
  int unsigned n_sent, n_checked, n_assign, n_merge, n_query, n_cfg;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard ceiling on the run, far above the slowest legal schedule.
  initial begin
    #(LIMIT_NS);
    $display("CHECK FAILED");
    $finish;
  end

  // Applies one operation to the shadow state and returns the report that the
  // block must produce for it. Sizes saturate at both ends, exactly as the
  // hardware counters do; an assign never shrinks the group it leaves.
  function automatic set_report_t apply_set_op(set_op_t op);
    logic [IDX_W-1:0] gx;
    logic [IDX_W-1:0] gy;
    set_report_t      rep;
    if (op.func == FUNC_ASSIGN) begin
      n_assign++;
      shadow_label[op.elem_x] = op.group_id;
      if (shadow_size[op.group_id] != SIZE_MAX)
        shadow_size[op.group_id] = shadow_size[op.group_id] + 1'b1;
    end else if (op.func == FUNC_MERGE) begin
      n_merge++;
      gx = shadow_label[op.elem_x];
      gy = shadow_label[op.elem_y];
      // Joining two elements that already share a label changes nothing.
      if (gx != gy) begin
        if (shadow_groups != '0)
          shadow_groups = shadow_groups - 1'b1;
        for (int i = 0; i < NUM_ELEM; i++) begin
          if (shadow_label[i] == gx) begin
            shadow_label[i] = gy;
            if (shadow_size[gx] != '0)
              shadow_size[gx] = shadow_size[gx] - 1'b1;
            if (shadow_size[gy] != SIZE_MAX)
              shadow_size[gy] = shadow_size[gy] + 1'b1;
          end
        end
      end
    end else begin
      n_query++;
    end
    gx = shadow_label[op.elem_x];
    rep.x_group          = gx;
    rep.same_group       = (gx == shadow_label[op.elem_y]);
    rep.x_group_size     = shadow_size[gx];
    rep.x_alone          = (shadow_size[gx] == SIZE_W'(1));
    rep.named_group_size = shadow_size[op.group_id];
    rep.group_count      = shadow_groups;
    return rep;
  endfunction

  // Element indexes lean toward a small pool so that merges hit shared groups
  // often, while the full range still shows up regularly.
  function automatic logic [IDX_W-1:0] pick_elem();
    if ($urandom_range(99) < 40)
      return IDX_W'($urandom_range(7));
    return IDX_W'($urandom_range(NUM_ELEM - 1));
  endfunction

  function automatic set_op_t random_set_op();
    set_op_t     op;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 35)
      op.func = FUNC_ASSIGN;
    else if (pick < 65)
      op.func = FUNC_MERGE;
    else if (pick < 90)
      op.func = FUNC_QUERY;
    else
      op.func = FUNC_SPARE;
    op.elem_x   = pick_elem();
    op.elem_y   = pick_elem();
    op.group_id = pick_elem();
    return op;
  endfunction

  // Presents one transaction, with random idle cycles ahead of it, and holds it
  // until the block accepts it. The expected report is queued at acceptance.
  task automatic send_set_op(input set_op_t op, input logic fixed_want,
                             input set_report_t want);
    set_report_t predicted;
    while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= op.func;
    in_elem_x   <= op.elem_x;
    in_elem_y   <= op.elem_y;
    in_group_id <= op.group_id;
    @(posedge clk);
    while (in_stall !== 1'b0)
      @(posedge clk);
    predicted = apply_set_op(op);
    pending_reports.push_back(fixed_want ? want : predicted);
    n_sent++;
  endtask

  // Stops sending and waits until every owed report has been taken. It always
  // advances the clock before returning, so back-to-back calls never drive in_valid
  // twice in one time step.
  task automatic drain_reports();
    in_valid <= 1'b0;
    do
      @(posedge clk);
    while (pending_reports.size() != 0);
  endtask

  // Register write: setup cycle, then access cycle. The write also reloads the
  // running group count, so the shadow count follows it. Before writing, the
  // register must still read back the last value written.
  task automatic write_initial_groups(input logic [SIZE_W-1:0] value);
    if (prdata !== CFG_DW'(initial_groups_reg)) begin
      failures++;
      if (failures <= 10)
        $display("%0t: register reads %0d, expected %0d",
                 $realtime, prdata, initial_groups_reg);
    end
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_INITIAL_GROUPS;
    pwdata  <= CFG_DW'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1)
      @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    initial_groups_reg = value;
    shadow_groups      = value;
    n_cfg++;
  endtask

  // Result side: random back-pressure, and a check of every accepted result
  // against the oldest owed report.
  always @(posedge clk) begin
    set_report_t seen;
    set_report_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      seen = '{out_x_group, out_same_group, out_x_group_size, out_x_alone,
               out_named_group_size, out_group_count};
      if (pending_reports.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: result with nothing owed: group %0d same %0b size %0d",
                   $realtime, seen.x_group, seen.same_group, seen.x_group_size);
      end else begin
        want = pending_reports.pop_front();
        n_checked++;
        if (seen !== want) begin
          failures++;
          if (failures <= 10) begin
            $display("%0t: result %0d mismatch, fields group/same/size/alone/named/count",
                     $realtime, n_checked);
            $display("  expected %0d %0b %0d %0b %0d %0d, got %0d %0b %0d %0b %0d %0d",
                     want.x_group, want.same_group, want.x_group_size, want.x_alone,
                     want.named_group_size, want.group_count,
                     seen.x_group, seen.same_group, seen.x_group_size, seen.x_alone,
                     seen.named_group_size, seen.group_count);
          end
        end
      end
    end
    out_stall <= gaps_on && ($urandom_range(99) < IDLE_PCT);
  end

  initial begin
    set_op_t          hammer;
    logic [SIZE_W-1:0] phase_groups [PHASES];

    // Every input starts at a known value.
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_func     = FUNC_QUERY;
    in_elem_x   = '0;
    in_elem_y   = '0;
    in_group_id = '0;
    out_stall   = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;

    for (int i = 0; i < NUM_ELEM; i++) begin
      shadow_label[i] = IDX_W'(i);
      shadow_size[i]  = '0;
    end
    initial_groups_reg = GROUPS_RESET;
    shadow_groups      = GROUPS_RESET;

    // Directed rows. The first five carry hand-written results: the reset
    // picture, both index extremes, the spare operation code and a first assign.
    // The rest cover merging an empty group (its size floors at zero), merges
    // of already joined elements, and whole groups moving into other groups.
    dir_table = '{
      '{'{FUNC_QUERY,  6'd0,  6'd63, 6'd0},  1'b1, '{6'd0,  1'b0, 7'd0, 1'b0, 7'd0, 7'd64}},
      '{'{FUNC_QUERY,  6'd63, 6'd63, 6'd63}, 1'b1, '{6'd63, 1'b1, 7'd0, 1'b0, 7'd0, 7'd64}},
      '{'{FUNC_SPARE,  6'd5,  6'd5,  6'd5},  1'b1, '{6'd5,  1'b1, 7'd0, 1'b0, 7'd0, 7'd64}},
      '{'{FUNC_SPARE,  6'd42, 6'd21, 6'd0},  1'b1, '{6'd42, 1'b0, 7'd0, 1'b0, 7'd0, 7'd64}},
      '{'{FUNC_ASSIGN, 6'd0,  6'd63, 6'd63}, 1'b1, '{6'd63, 1'b1, 7'd1, 1'b1, 7'd1, 7'd64}},
      '{'{FUNC_ASSIGN, 6'd1,  6'd0,  6'd63}, 1'b0, NO_REPORT},
      '{'{FUNC_MERGE,  6'd2,  6'd0,  6'd2},  1'b0, NO_REPORT},
      '{'{FUNC_MERGE,  6'd0,  6'd2,  6'd63}, 1'b0, NO_REPORT},
      '{'{FUNC_MERGE,  6'd63, 6'd1,  6'd0},  1'b0, NO_REPORT},
      '{'{FUNC_ASSIGN, 6'd10, 6'd11, 6'd0},  1'b0, NO_REPORT},
      '{'{FUNC_ASSIGN, 6'd11, 6'd10, 6'd0},  1'b0, NO_REPORT},
      '{'{FUNC_MERGE,  6'd10, 6'd21, 6'd21}, 1'b0, NO_REPORT},
      '{'{FUNC_MERGE,  6'd63, 6'd10, 6'd0},  1'b0, NO_REPORT},
      '{'{FUNC_QUERY,  6'd21, 6'd0,  6'd63}, 1'b0, NO_REPORT},
      '{'{FUNC_ASSIGN, 6'd63, 6'd63, 6'd0},  1'b0, NO_REPORT},
      '{'{FUNC_MERGE,  6'd42, 6'd63, 6'd42}, 1'b0, NO_REPORT},
      '{'{FUNC_ASSIGN, 6'd62, 6'd62, 6'd62}, 1'b0, NO_REPORT},
      '{'{FUNC_MERGE,  6'd61, 6'd62, 6'd61}, 1'b0, NO_REPORT},
      '{'{FUNC_SPARE,  6'd63, 6'd0,  6'd21}, 1'b0, NO_REPORT},
      '{'{FUNC_QUERY,  6'd62, 6'd61, 6'd62}, 1'b0, NO_REPORT}
    };

    // Group count settings per random phase: empty (merges must not wrap the
    // count below zero), all ones, one, the reset value, then a random one.
    phase_groups = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd0};
    phase_groups[PHASES-1] = SIZE_W'($urandom_range(127));

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // The block stalls input during its clearing pass after reset; the
    // handshake alone takes care of that.
    for (int r = 0; r < DIR_ROWS; r++)
      send_set_op(dir_table[r].op, dir_table[r].fixed_want, dir_table[r].want);

    for (int p = 0; p < PHASES; p++) begin
      // The register is only written with nothing in flight.
      drain_reports();
      write_initial_groups(phase_groups[p]);
      // One phase runs with no idle cycles on either side.
      gaps_on = (p != 3);

      // In the all-ones phase, assign one element to one group over and over
      // until the group size saturates, then merge that group away so the
      // saturated size is moved off one member at a time.
      if (p == 1) begin
        hammer          = random_set_op();
        hammer.func     = FUNC_ASSIGN;
        hammer.group_id = hammer.elem_x;
        for (int k = 0; k < HAMMER_ITEMS; k++)
          send_set_op(hammer, 1'b0, NO_REPORT);
        hammer.func   = FUNC_MERGE;
        hammer.elem_y = ~hammer.elem_x;
        send_set_op(hammer, 1'b0, NO_REPORT);
      end

      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_set_op(random_set_op(), 1'b0, NO_REPORT);
        // Now and then the sender holds off until the result side is empty.
        if ($urandom_range(99) == 0)
          drain_reports();
      end
    end

    gaps_on = 1'b1;
    drain_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Ran %0d transactions: %0d assign, %0d merge, %0d query or spare code.",
             n_sent, n_assign, n_merge, n_query);
    $display("Checked %0d results across %0d group count settings, %0d failures.",
             n_checked, n_cfg, failures);
    if (failures == 0 && pending_reports.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

@@ files.f @@
src/qfds_pkg.sv
src/qfds_ram.sv
src/qfds_sat_unit.sv
src/quick_find_disjoint_set.sv
tb/tb_quick_find_disjoint_set.sv
